[rtl/swm_pkg.sv]
// Shared constants and types for the sliding-window median core.
// Used by swm_cell, sliding_window_median_core and the testbench; depends on nothing else.
package swm_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int LEN_W        = 7;
    localparam int IDX_W        = 6;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(5);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_WINDOW);

    // What one cell shows its neighbours.
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] val;
        logic                           vld;
        logic                           lt_o;
        logic                           le_s;
    } swm_link_t;

    // What every cell receives from the control logic.
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic signed [SAMPLE_WIDTH-1:0] oldest;
        logic                           rem;
        logic                           restart;
        logic                           en;
        logic                           clr;
    } swm_bcast_t;

endpackage

[rtl/swm_cell.sv]
// One cell of the sorted window: holds one sample and its valid flag.
// Depends on swm_pkg for the link and broadcast types.
module swm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  swm_pkg::swm_bcast_t bcast,
    input  swm_pkg::swm_link_t  prev_link,
    input  swm_pkg::swm_link_t  next_link,
    output swm_pkg::swm_link_t  own_link
);
    import swm_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] val_reg;
    logic signed [SAMPLE_WIDTH-1:0] val_next;
    logic                           vld_reg;
    logic                           vld_next;
    logic                           vld_eff;
    logic                           left_own;
    logic                           left_prev;
    logic signed [SAMPLE_WIDTH-1:0] cj_val;
    logic                           cj_vld;
    logic                           cj_le;
    logic signed [SAMPLE_WIDTH-1:0] cp_val;
    logic                           cp_vld;
    logic                           cp_le;

    // A restart makes the whole window empty for the transaction that carries it.
    assign vld_eff = vld_reg && !bcast.restart;

    always_comb
    begin
        own_link.val  = val_reg;
        own_link.vld  = vld_eff;
        own_link.lt_o = vld_eff && (val_reg < bcast.oldest);
        own_link.le_s = vld_eff && (val_reg <= bcast.sample);
    end

    // Equal values sit oldest first, so the cells left of the oldest sample are
    // exactly those holding a smaller value. Removal closes the gap from the right.
    always_comb
    begin
        left_own  = !bcast.rem || own_link.lt_o;
        left_prev = !bcast.rem || prev_link.lt_o;
        cj_val    = left_own ? val_reg : next_link.val;
        cj_vld    = left_own ? vld_eff : next_link.vld;
        cj_le     = left_own ? own_link.le_s : next_link.le_s;
        cp_val    = left_prev ? prev_link.val : val_reg;
        cp_vld    = left_prev ? prev_link.vld : vld_eff;
        cp_le     = left_prev ? prev_link.le_s : own_link.le_s;
        if (cj_le)
        begin
            val_next = cj_val;
            vld_next = cj_vld;
        end
        else if (cp_le)
        begin
            val_next = bcast.sample;
            vld_next = 1'b1;
        end
        else
        begin
            val_next = cp_val;
            vld_next = cp_vld;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (bcast.clr)
        begin
            vld_reg <= 1'b0;
        end
        else if (bcast.en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bcast.en)
        begin
            val_reg <= val_next;
        end
    end

endmodule

[rtl/sliding_window_median_core.sv]
// Sliding-window median core: a row of sorted cells, an arrival ring and the stream control.
// Depends on swm_pkg and swm_cell.
//
// The core takes one sample transaction per clock while the one-entry pending
// stage is free or emptying and, once the window holds window_len samples, passes
// the lower median of the window through that stage to the output register. Every
// cell updates in the same cycle from its two neighbours, so the rate is set by
// the insert-and-remove step of the cell row together with the arrival ring,
// whose registered read fetches the next oldest sample ahead of time. Input is
// still taken while a result stalls in the output register alone. A write of
// window_len or a transaction with restart set empties the window; no clearing
// pass is needed, since only ring entries written since then are read.
module sliding_window_median_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [swm_pkg::LEN_W-1:0]          cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [swm_pkg::SAMPLE_WIDTH-1:0]   s_axis_tdata,  // [15:0] sample
    input  logic                               s_axis_tuser,  // [0] restart
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [swm_pkg::SAMPLE_WIDTH-1:0]   m_axis_tdata   // [15:0] median
);
    import swm_pkg::*;

    logic [LEN_W-1:0]        win_len_reg;
    logic [LEN_W-1:0]        fill_reg;
    logic [LEN_W-1:0]        fill_next;
    logic [IDX_W-1:0]        ptr_reg;
    logic [IDX_W-1:0]        ptr_next;
    logic                    pend_reg;
    logic                    out_vld_reg;
    logic [SAMPLE_WIDTH-1:0] out_data_reg;
    logic [SAMPLE_WIDTH-1:0] old_reg;
    logic [SAMPLE_WIDTH-1:0] ring_mem [MAX_WINDOW];

    logic [LEN_W-1:0]        len;
    logic [IDX_W-1:0]        mid;
    logic                    accept;
    logic                    restart;
    logic                    rem;
    logic                    result;
    logic                    load;
    logic [LEN_W-1:0]        fill_eff;
    logic [LEN_W-1:0]        ptr_inc;
    logic [IDX_W-1:0]        wr_addr;
    logic [MAX_WINDOW-1:0]   vld_vec;

    swm_bcast_t              bcast;
    swm_link_t               links [MAX_WINDOW];
    swm_link_t               head_link;
    swm_link_t               tail_link;

    always_comb
    begin
        if (win_len_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (win_len_reg > LEN_MAX)
        begin
            len = LEN_MAX;
        end
        else
        begin
            len = win_len_reg;
        end
    end

    assign mid = IDX_W'((len - LEN_W'(1)) >> 1);

    assign load          = pend_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !pend_reg || load;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign restart       = accept && s_axis_tuser;

    always_comb
    begin
        fill_eff  = restart ? '0 : fill_reg;
        rem       = (fill_eff == len);
        ptr_inc   = {1'b0, ptr_reg} + LEN_W'(1);
        wr_addr   = rem ? ptr_reg : fill_eff[IDX_W-1:0];
        fill_next = rem ? len : fill_eff + LEN_W'(1);
        result    = (fill_next == len);
        if (rem && ptr_inc != len)
        begin
            ptr_next = ptr_inc[IDX_W-1:0];
        end
        else
        begin
            ptr_next = '0;
        end
    end

    always_comb
    begin
        bcast.sample  = s_axis_tdata;
        bcast.oldest  = old_reg;
        bcast.rem     = rem;
        bcast.restart = restart;
        bcast.en      = accept;
        bcast.clr     = cfg_we;
        head_link.val  = '0;
        head_link.vld  = 1'b1;
        head_link.lt_o = 1'b1;
        head_link.le_s = 1'b1;
        tail_link      = '0;
    end

    for (genvar j = 0; j < MAX_WINDOW; j++)
    begin : g_cell
        swm_link_t prev_l;
        swm_link_t next_l;

        if (j == 0)
        begin : g_head
            assign prev_l = head_link;
        end
        else
        begin : g_mid_prev
            assign prev_l = links[j-1];
        end

        if (j == MAX_WINDOW - 1)
        begin : g_tail
            assign next_l = tail_link;
        end
        else
        begin : g_mid_next
            assign next_l = links[j+1];
        end

        swm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .bcast     (bcast),
            .prev_link (prev_l),
            .next_link (next_l),
            .own_link  (links[j])
        );

        assign vld_vec[j] = links[j].vld;
    end

    // The ring is written with the new sample and read ahead at the slot that
    // will hold the oldest sample for the next transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_mem[wr_addr] <= s_axis_tdata;
            if (wr_addr == ptr_next)
            begin
                old_reg <= s_axis_tdata;
            end
            else
            begin
                old_reg <= ring_mem[ptr_next];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg <= LEN_RESET;
            fill_reg    <= '0;
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                win_len_reg <= cfg_wdata;
                fill_reg    <= '0;
                ptr_reg     <= '0;
            end
            else if (accept)
            begin
                fill_reg <= fill_next;
                ptr_reg  <= ptr_next;
            end

            if (accept)
            begin
                pend_reg <= result;
            end
            else if (load)
            begin
                pend_reg <= 1'b0;
            end

            if (load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // The cells still hold the window of the pending result in this cycle.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= links[mid].val;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // The valid cells form an unbroken run from the left end of the row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_vec & (vld_vec + MAX_WINDOW'(1))) == '0)
    else $error("valid cells are not contiguous");

    // The number of valid cells always equals the fill count seen by this cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(vld_vec) == int'(fill_eff))
    else $error("fill count disagrees with valid cells");

    // A pending result always belongs to a full window.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && !cfg_we |-> fill_reg == len)
    else $error("result pending while the window is not full");

endmodule

[verif/tb_sliding_window_median_core.sv]
// Self-checking testbench for sliding_window_median_core: a queue-fed stream driver,
// a stream monitor and a sorted-window median predictor checked transaction by transaction.
// Depends on swm_pkg and the core RTL only.
module tb_sliding_window_median_core;

    import swm_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 1000;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] sample_value;
        bit                             restart;
        bit                             drain_first;
    } sample_item_t;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    cfg_we        = 1'b0;
    logic [LEN_W-1:0]        cfg_wdata     = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [SAMPLE_WIDTH-1:0] s_axis_tdata  = '0;  // [15:0] sample
    logic                    s_axis_tuser  = 1'b0; // [0] restart
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [SAMPLE_WIDTH-1:0] m_axis_tdata;        // [15:0] median

    sample_item_t                   sample_queue[$];
    logic signed [SAMPLE_WIDTH-1:0] median_queue[$];

    int pushed_total   = 0;
    int accepted_total = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;
    int send_gap       = 0;
    int recv_gap       = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    bit sample_taken   = 1'b0;

    // Predictor state: window contents in arrival order and in ascending order.
    logic signed [SAMPLE_WIDTH-1:0] arrival_copy[MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] sorted_copy[MAX_WINDOW];
    logic [LEN_W-1:0]               window_len_copy = LEN_RESET;
    int                             fill_copy       = 0;
    int                             oldest_copy     = 0;

    logic signed [SAMPLE_WIDTH-1:0] predicted_median;
    logic signed [SAMPLE_WIDTH-1:0] expected_median;
    bit                             median_due;
    sample_item_t                   next_item;
    bit                             drive_valid;

    sliding_window_median_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Inserts a value into the first count entries of the ascending copy.
    function automatic void sorted_insert(int count, logic signed [SAMPLE_WIDTH-1:0] v);
        int i;
        i = count;
        while (i > 0 && sorted_copy[i-1] > v)
        begin
            sorted_copy[i] = sorted_copy[i-1];
            i--;
        end
        sorted_copy[i] = v;
    endfunction

    // Advances the window by one sample; returns 1 when the window is full.
    function automatic bit next_median(logic signed [SAMPLE_WIDTH-1:0] v, bit restart,
                                       output logic signed [SAMPLE_WIDTH-1:0] med);
        int len;
        int p;
        int i;
        len = (window_len_copy == 0) ? 1 :
              (window_len_copy > LEN_MAX) ? MAX_WINDOW : int'(window_len_copy);
        med = '0;
        if (restart)
        begin
            fill_copy   = 0;
            oldest_copy = 0;
        end
        if (fill_copy >= len)
        begin
            p = oldest_copy % len;
            // Drop one copy of the oldest value; with duplicates any copy will do.
            i = 0;
            while (i < len && sorted_copy[i] != arrival_copy[p])
                i++;
            for (; i + 1 < len; i++)
                sorted_copy[i] = sorted_copy[i+1];
            sorted_insert(len - 1, v);
            arrival_copy[p] = v;
            oldest_copy     = (p + 1) % len;
            fill_copy       = len;
        end
        else
        begin
            arrival_copy[fill_copy] = v;
            sorted_insert(fill_copy, v);
            fill_copy++;
            oldest_copy = 0;
        end
        if (fill_copy < len)
            return 1'b0;
        med = sorted_copy[(len - 1) / 2];
        return 1'b1;
    endfunction

    // Monitor: predicts on every accepted sample and checks every accepted median.
    always @(posedge clk)
    begin
        sample_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                window_len_copy = cfg_wdata;
                fill_copy       = 0;
                oldest_copy     = 0;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                sample_taken = 1'b1;
                accepted_total++;
                if (next_median($signed(s_axis_tdata), s_axis_tuser, predicted_median))
                    median_queue.push_back(predicted_median);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (median_queue.size() == 0)
                begin
                    $display("%0t: median with none expected, expected none, actual %0d",
                             $time, $signed(m_axis_tdata));
                    mismatch_count++;
                end
                else
                begin
                    expected_median = median_queue.pop_front();
                    if (m_axis_tdata !== expected_median)
                    begin
                        $display("%0t: median mismatch, expected %0d, actual %0d",
                                 $time, expected_median, $signed(m_axis_tdata));
                        mismatch_count++;
                    end
                end
            end
            if (sample_taken || (m_axis_tvalid && m_axis_tready) || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    always @(posedge clk)
    begin
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_sliding_window_median_core: FAIL");
            $finish;
        end
    end

    // Driver: presents queued samples, with random idle bursts between transactions.
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || sample_taken))
        begin
            if (send_gap == 0 && send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
                send_gap = $urandom_range(1, 8);
            drive_valid = 1'b0;
            if (send_gap != 0)
                send_gap--;
            else if (sample_queue.size() != 0 &&
                     !(sample_queue[0].drain_first && median_queue.size() != 0))
            begin
                next_item     = sample_queue.pop_front();
                drive_valid   = 1'b1;
                s_axis_tdata <= next_item.sample_value;
                s_axis_tuser <= next_item.restart;
            end
            s_axis_tvalid <= drive_valid;
        end
    end

    // Result sink: ready held low in random bursts.
    always @(negedge clk)
    begin
        if (recv_gap != 0)
        begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end
        else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct)
        begin
            recv_gap = $urandom_range(1, 8) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic queue_sample(logic signed [SAMPLE_WIDTH-1:0] v, bit restart,
                                bit drain_first = 1'b0);
        sample_item_t item;
        item.sample_value = v;
        item.restart      = restart;
        item.drain_first  = drain_first;
        sample_queue.push_back(item);
        pushed_total++;
    endtask

    // Mostly plain streams; some extremes and clustered values to force duplicates.
    task automatic queue_random(int count, int restart_odds);
        logic signed [SAMPLE_WIDTH-1:0] v;
        bit                             restart;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(9))
                0:       v = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                1, 2:    v = SAMPLE_WIDTH'($signed($urandom_range(8)) - 4);
                default: v = SAMPLE_WIDTH'($urandom);
            endcase
            restart = (restart_odds != 0) && ($urandom_range(restart_odds - 1) == 0);
            queue_sample(v, restart, $urandom_range(99) == 0);
        end
    endtask

    // Waits until every sample is taken and every median has come, then lets the core settle.
    task automatic settle();
        while (accepted_total != pushed_total || median_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(logic [LEN_W-1:0] len, int count, int restart_odds,
                             int s_pct, int r_pct);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(negedge clk);
        cfg_we        <= 1'b0;
        send_idle_pct  = s_pct;
        recv_idle_pct  = r_pct;
        queue_random(count, restart_odds);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 20;
        recv_idle_pct = 20;

        // Reset window length of five: extremes, duplicates and restarts in each state.
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(16'sh0000, 1'b0);
        queue_sample(-16'sd1, 1'b0);
        queue_sample(16'sd1, 1'b0);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh5555, 1'b0);
        queue_sample(16'shAAAA, 1'b0);
        queue_sample(16'sd7, 1'b1, 1'b1);
        queue_sample(16'sd3, 1'b0);
        queue_sample(16'sd3, 1'b0);
        queue_sample(16'sd9, 1'b1);
        queue_sample(16'sd9, 1'b0);
        queue_sample(16'sd9, 1'b0);
        queue_sample(16'sd9, 1'b0);
        queue_sample(16'sd9, 1'b0);
        queue_sample(-16'sd5, 1'b1);
        queue_sample(16'sd2, 1'b0);
        queue_sample(16'sd4, 1'b0);
        queue_random(120, 30);

        // Zero acts as one, and lengths above the maximum saturate.
        run_phase(7'd0, 80, 20, 20, 20);
        run_phase(7'd1, 60, 10, 30, 10);
        run_phase(7'd127, 150, 400, 15, 25);
        run_phase(7'd64, 150, 300, 20, 20);
        run_phase(7'd65, 100, 0, 10, 30);
        run_phase(7'd2, 80, 15, 25, 25);
        run_phase(7'd3, 80, 20, 0, 0);
        run_phase(7'($urandom_range(4, 63)), 120, 100, 20, 20);
        run_phase(7'd5, 140, 25, 0, 0);

        settle();
        if (mismatch_count == 0)
            $display("tb_sliding_window_median_core: PASS");
        else
            $display("tb_sliding_window_median_core: FAIL");
        $finish;
    end

endmodule
